// ----- rtl/rfc_pkg.sv -----
// rfc_pkg: shared types and constants of the response frame checker
// result item layout, front-to-queue write bundle, frame byte codes, verdict codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // frame byte codes
    localparam logic [7:0] HDR_SYNC     = 8'hFF;
    localparam logic [7:0] HDR_ADDR     = 8'h2F;
    localparam logic [7:0] HDR_ADDR_ALT = 8'h1F;
    localparam logic [7:0] HDR_CMD      = 8'h30;
    localparam logic [7:0] TRL_ETX      = 8'h03;
    localparam logic [7:0] TRL_CR       = 8'h0D;
    localparam logic [7:0] TRL_LF       = 8'h0A;

    // status byte masks
    localparam logic [7:0] STS_VALID_MASK = 8'h40;
    localparam logic [7:0] STS_FAULT_MASK = 8'h90;
    localparam logic [7:0] STS_ERR_MASK   = 8'h0F;
    localparam logic [7:0] STS_READY_MASK = 8'h20;

    // byte positions inside a frame
    localparam logic [2:0] IDX_SYNC     = 3'd0;
    localparam logic [2:0] IDX_ADDR     = 3'd1;
    localparam logic [2:0] IDX_CMD      = 3'd2;
    localparam logic [2:0] IDX_STATUS   = 3'd3;
    localparam logic [2:0] IDX_LAST_MIN = 3'd6;
    localparam logic [2:0] IDX_PAYLOAD  = 3'd7;

    // verdict codes
    localparam logic [2:0] VRD_OK        = 3'd0;
    localparam logic [2:0] VRD_SHORT     = 3'd1;
    localparam logic [2:0] VRD_FRAMING   = 3'd2;
    localparam logic [2:0] VRD_FLAGS     = 3'd3;
    localparam logic [2:0] VRD_DEV_ERROR = 3'd4;
    localparam logic [2:0] VRD_BUSY      = 3'd5;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] verdict;
        logic [3:0] device_error;
        logic       frame_end;
    } t_item;

    // up to two items written by the front per accepted input item
    typedef struct packed {
        logic  wr0;
        logic  wr1;
        t_item item0;
        t_item item1;
    } t_push_bundle;

    // queue status toward the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- rtl/rfc_front.sv -----
// rfc_front: per-frame state, header/trailer/status checks, payload delay line
// produces up to two result items for each accepted input item
// depends on rfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [7:0]            i_rx_byte,
    input  wire                  i_end_of_response,
    input  wire                  i_cfg_wr,
    input  wire                  i_cfg_data,
    output rfc_pkg::t_push_bundle o_push
);
    import rfc_pkg::*;

    logic [2:0] r_byte_count, n_byte_count;
    logic       r_header_ok,  n_header_ok;
    logic [7:0] r_status_byte, n_status_byte;
    logic [7:0] r_tail [3];
    logic [7:0] n_tail [3];
    logic       r_alt_hdr;

    logic       hdr_bad;
    logic       trailer_ok;
    logic [7:0] status;
    logic [2:0] verdict;
    logic [3:0] dev_err;
    t_item      pay_item;
    t_item      vrd_item;

    // header byte checks at their positions
    always_comb begin
        hdr_bad = 1'b0;
        case (r_byte_count)
            IDX_SYNC: hdr_bad = (i_rx_byte != HDR_SYNC);
            IDX_ADDR: hdr_bad = !((i_rx_byte == HDR_ADDR) ||
                                  (r_alt_hdr && (i_rx_byte == HDR_ADDR_ALT)));
            IDX_CMD:  hdr_bad = (i_rx_byte != HDR_CMD);
            default:  hdr_bad = 1'b0;
        endcase
    end

    // status byte as seen by this item (captured on the fourth byte)
    assign status = (r_byte_count == IDX_STATUS) ? i_rx_byte : r_status_byte;

    // trailer: last three bytes after the shift
    assign trailer_ok = (r_tail[1] == TRL_ETX) && (r_tail[2] == TRL_CR) &&
                        (i_rx_byte == TRL_LF);

    // verdict priority chain
    always_comb begin
        dev_err = 4'd0;
        if (r_byte_count < IDX_LAST_MIN) begin
            verdict = VRD_SHORT;
        end else if (!(r_header_ok && !hdr_bad) || !trailer_ok) begin
            verdict = VRD_FRAMING;
        end else if (((status & STS_VALID_MASK) == 8'd0) ||
                     ((status & STS_FAULT_MASK) != 8'd0)) begin
            verdict = VRD_FLAGS;
        end else if ((status & STS_ERR_MASK) != 8'd0) begin
            verdict = VRD_DEV_ERROR;
            dev_err = status[3:0];
        end else if ((status & STS_READY_MASK) == 8'd0) begin
            verdict = VRD_BUSY;
        end else begin
            verdict = VRD_OK;
        end
    end

    // item assembly
    always_comb begin
        pay_item              = '0;
        pay_item.kind         = KIND_PAYLOAD;
        pay_item.data_byte    = r_tail[0];
        vrd_item              = '0;
        vrd_item.kind         = KIND_VERDICT;
        vrd_item.verdict      = verdict;
        vrd_item.device_error = dev_err;
        vrd_item.frame_end    = 1'b1;
    end

    // pack payload first, verdict after it
    always_comb begin
        o_push = '0;
        if (i_accept) begin
            if (r_byte_count == IDX_PAYLOAD) begin
                o_push.wr0   = 1'b1;
                o_push.item0 = pay_item;
                o_push.wr1   = i_end_of_response;
                o_push.item1 = vrd_item;
            end else begin
                o_push.wr0   = i_end_of_response;
                o_push.item0 = vrd_item;
            end
        end
    end

    // next frame state
    always_comb begin
        n_byte_count  = r_byte_count;
        n_header_ok   = r_header_ok;
        n_status_byte = r_status_byte;
        n_tail        = r_tail;
        if (i_accept) begin
            if (i_end_of_response) begin
                n_byte_count  = 3'd0;
                n_header_ok   = 1'b1;
                n_status_byte = 8'd0;
                n_tail[0]     = 8'd0;
                n_tail[1]     = 8'd0;
                n_tail[2]     = 8'd0;
            end else begin
                n_byte_count  = (r_byte_count == IDX_PAYLOAD) ? r_byte_count
                                                              : r_byte_count + 3'd1;
                n_header_ok   = r_header_ok && !hdr_bad;
                n_status_byte = status;
                n_tail[0]     = r_tail[1];
                n_tail[1]     = r_tail[2];
                n_tail[2]     = i_rx_byte;
            end
        end
    end

    // frame state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= 3'd0;
            r_header_ok   <= 1'b1;
            r_status_byte <= 8'd0;
            r_tail[0]     <= 8'd0;
            r_tail[1]     <= 8'd0;
            r_tail[2]     <= 8'd0;
            r_alt_hdr     <= 1'b1;
        end else begin
            r_byte_count  <= n_byte_count;
            r_header_ok   <= n_header_ok;
            r_status_byte <= n_status_byte;
            r_tail        <= n_tail;
            if (i_cfg_wr) begin
                r_alt_hdr <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rfc_queue.sv -----
// rfc_queue: result queue, two writes and one read per cycle
// keeps room for the two items a single input item can produce
// depends on rfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfc_queue #(
    parameter int DEPTH = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire rfc_pkg::t_push_bundle   i_push,
    input  wire                          i_pop,
    output rfc_pkg::t_item               o_head,
    output wire rfc_pkg::t_q_status      o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    import rfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_LVL = CW'(DEPTH - 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_level,  n_level;
    logic [PW-1:0] wr_ptr1;
    logic          rd_en;
    logic [CW-1:0] n_wr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign rd_en   = i_pop && (r_level != '0);
    assign n_wr    = CW'(i_push.wr0) + CW'(i_push.wr1);

    // pointer and level bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.wr1) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end else if (i_push.wr0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = rd_en ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_level  = r_level + n_wr - CW'(rd_en);
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.wr1) begin
            r_mem[wr_ptr1] <= i_push.item1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // head of queue and status
    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level >= FULL_LVL);
    assign o_level        = r_level;

endmodule

`default_nettype wire

// ----- rtl/response_frame_checker.sv -----
// response_frame_checker: top level, front checker plus result queue
// depends on rfc_pkg, rfc_front, rfc_queue
//
// Usage:
//   Input channel: drive rx_byte and end_of_response with push; a byte is taken
//   at a clock edge with push high and full low. end_of_response marks the
//   final byte of a response.
//   Result channel: while empty is low the oldest result item sits on the
//   result ports; pop at an edge with empty low takes it.
//   Config channel: cfg_valid/cfg_ready write accept_alt_header; ready is
//   always high. Write only while no frame is in progress.
// Throughput: one byte per cycle while full is low. Each byte yields zero, one
//   or two items (a payload byte, then the verdict on the final byte).
// Latency: payload bytes trail input by three bytes. An item written at the
//   accepting edge into an empty queue shows on the result ports the next cycle.
// Stall: full rises when fewer than two queue entries are free, so input
//   keeps flowing at one byte per cycle as long as pop is held high.
// Reset: synchronous, active low; clears frame state and the queue, and sets
//   accept_alt_header to 1.
`timescale 1ns / 1ps
`default_nettype none

module response_frame_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_end_of_response,
    output logic       empty,
    input  wire        pop,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_verdict,
    output logic [3:0] o_device_error,
    output logic       o_frame_end,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_data
);
    import rfc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_push_bundle  push_bus;
    t_item         head;
    t_q_status     q_status;
    logic [CW-1:0] q_level;
    logic          in_accept;
    logic          out_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !q_status.full;
    assign out_accept  = pop && !q_status.empty;

    // byte checker
    rfc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_response (i_end_of_response),
        .i_cfg_wr          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_push            (push_bus)
    );

    // result queue
    rfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push_bus),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status),
        .o_level  (q_level)
    );

    // result ports
    assign full           = q_status.full;
    assign empty          = q_status.empty;
    assign o_kind         = head.kind;
    assign o_data_byte    = head.data_byte;
    assign o_verdict      = head.verdict;
    assign o_device_error = head.device_error;
    assign o_frame_end    = head.frame_end;

    // queue level never passes its depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= CW'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // a final byte always leaves a verdict waiting
    a_verdict_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_end_of_response |=> !empty)
        else $error("final byte produced no result");

    // the only item leaving with nothing arriving empties the queue
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && (q_level == CW'(1)) && !in_accept |=> empty)
        else $error("queue not empty after last item taken");

    // a payload item never claims to close a frame or carries a verdict
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_kind == KIND_PAYLOAD) |-> !o_frame_end && (o_verdict == VRD_OK))
        else $error("payload item with verdict fields set");

endmodule

`default_nettype wire
